@@ hw/rtl/cle_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, action and status codes for the circular list engine.
package cle_pkg;

    // Action codes carried on the input beat
    localparam logic [2:0] ACT_INS_FRONT = 3'd0;
    localparam logic [2:0] ACT_INS_BACK  = 3'd1;
    localparam logic [2:0] ACT_SEARCH    = 3'd2;
    localparam logic [2:0] ACT_INS_AFTER = 3'd3;
    localparam logic [2:0] ACT_DEL_FIRST = 3'd4;
    localparam logic [2:0] ACT_DUMP      = 3'd5;

    // Status codes carried on the result beat
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd4;

    // Read address source for the node memories
    typedef enum logic [1:0] {
        RD_TAIL,
        RD_PREV,
        RD_LINK
    } rd_sel_t;

    // Result beat source
    typedef enum logic [2:0] {
        RES_FULL,
        RES_BAD,
        RES_EMPTY,
        RES_MISS,
        RES_INSERT,
        RES_NODE
    } res_sel_t;

    typedef struct packed {
        logic     in_load;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     scan_clr;
        logic     scan_inc;
        logic     slot_load;
        logic     cur_load;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     ins_node;
        logic     ins_first;
        logic     link_prev;
        logic     del_head;
        logic     out_load;
        res_sel_t res_sel;
        logic     out_last;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       nonempty;
        logic       handle_ok;
        logic       scan_free;
        logic       scan_last;
        logic       hit;
        logic       at_tail;
        logic       cnt_last;
    } sts_t;

endpackage

@@ hw/rtl/cle_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the circular list engine: decodes actions and drives the datapath.
module cle_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  cle_pkg::sts_t sts,
    output cle_pkg::cmd_t cmd
);
    import cle_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_INS_A,
        S_INS_B,
        S_HEAD,
        S_SEARCH,
        S_DELETE,
        S_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   dump_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign dump_last = sts.at_tail || sts.cnt_last;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.action)
                    ACT_INS_FRONT, ACT_INS_BACK:
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_FIND;
                    end
                    ACT_INS_AFTER:
                    begin
                        if (sts.handle_ok)
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_FIND;
                        end
                        else
                        begin
                            cmd.res_sel  = RES_BAD;
                            cmd.out_last = 1'b1;
                            if (out_free)
                            begin
                                cmd.out_load = 1'b1;
                                state_next   = S_IDLE;
                            end
                        end
                    end
                    ACT_SEARCH, ACT_DEL_FIRST, ACT_DUMP:
                    begin
                        if (sts.nonempty)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_TAIL;
                            state_next = S_HEAD;
                        end
                        else
                        begin
                            cmd.res_sel  = (sts.action == ACT_SEARCH) ? RES_MISS : RES_EMPTY;
                            cmd.out_last = 1'b1;
                            if (out_free)
                            begin
                                cmd.out_load = 1'b1;
                                state_next   = S_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FIND:
            begin
                if (sts.scan_free)
                begin
                    cmd.slot_load = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = RD_PREV;
                    state_next    = S_INS_A;
                end
                else if (sts.scan_last)
                begin
                    cmd.res_sel  = RES_FULL;
                    cmd.out_last = 1'b1;
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_INS_A:
            begin
                cmd.res_sel  = RES_INSERT;
                cmd.out_last = 1'b1;
                if (sts.nonempty)
                begin
                    cmd.ins_node = 1'b1;
                    state_next   = S_INS_B;
                end
                else if (out_free)
                begin
                    cmd.ins_node  = 1'b1;
                    cmd.ins_first = 1'b1;
                    cmd.out_load  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_INS_B:
            begin
                cmd.res_sel  = RES_INSERT;
                cmd.out_last = 1'b1;
                if (out_free)
                begin
                    cmd.link_prev = 1'b1;
                    cmd.out_load  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_HEAD:
            begin
                cmd.cur_load = 1'b1;
                cmd.cnt_clr  = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_LINK;
                if (sts.action == ACT_SEARCH)
                begin
                    state_next = S_SEARCH;
                end
                else if (sts.action == ACT_DEL_FIRST)
                begin
                    state_next = S_DELETE;
                end
                else
                begin
                    state_next = S_DUMP;
                end
            end
            S_SEARCH:
            begin
                cmd.out_last = 1'b1;
                if (sts.hit)
                begin
                    cmd.res_sel = RES_NODE;
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (dump_last)
                begin
                    cmd.res_sel = RES_MISS;
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.cur_load = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_LINK;
                end
            end
            S_DELETE:
            begin
                cmd.res_sel  = RES_NODE;
                cmd.out_last = 1'b1;
                if (out_free)
                begin
                    cmd.del_head = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP:
            begin
                cmd.res_sel  = RES_NODE;
                cmd.out_last = dump_last;
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.cur_load = 1'b1;
                        cmd.cnt_inc  = 1'b1;
                        cmd.rd_en    = 1'b1;
                        cmd.rd_sel   = RD_LINK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || cmd.out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/cle_datapath.sv @@
`timescale 1ns / 1ps
// Node pool storage, list pointers, scan counters and result register.
module cle_datapath #(
    parameter int POOL_DEPTH = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          action,
    input  logic signed [31:0]  value,
    input  logic [3:0]          handle,
    input  cle_pkg::cmd_t       cmd,
    output cle_pkg::sts_t       sts,
    output logic [2:0]          status,
    output logic [3:0]          node_handle,
    output logic signed [31:0]  item_out,
    output logic                last_result
);
    import cle_pkg::*;

    localparam int SW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(POOL_DEPTH - 1);

    // node memories
    logic [ITEM_WIDTH-1:0] val_mem [POOL_DEPTH];
    logic [SW-1:0]         link_mem [POOL_DEPTH];

    logic [POOL_DEPTH-1:0] in_use_reg;
    logic [POOL_DEPTH-1:0] in_use_next;
    logic [SW-1:0]         tail_reg;
    logic [SW-1:0]         tail_next;
    logic                  nonempty_reg;
    logic                  nonempty_next;

    logic [2:0]            action_reg;
    logic [ITEM_WIDTH-1:0] item_reg;
    logic [3:0]            handle_reg;
    logic [SW-1:0]         scan_reg;
    logic [SW-1:0]         slot_reg;
    logic [SW-1:0]         cur_reg;
    logic [SW-1:0]         cnt_reg;
    logic [ITEM_WIDTH-1:0] rd_val_reg;
    logic [SW-1:0]         rd_link_reg;

    logic [2:0]            status_reg;
    logic [3:0]            node_handle_reg;
    logic [31:0]           item_out_reg;
    logic                  last_result_reg;

    logic [ITEM_WIDTH-1:0] item_in;
    logic [SW-1:0]         handle_slot;
    logic [SW-1:0]         prev_slot;
    logic [SW-1:0]         rd_addr;
    logic                  link_we;
    logic [SW-1:0]         link_waddr;
    logic [SW-1:0]         link_wdata;
    logic                  at_tail;
    logic                  tail_moves;
    logic [2:0]            res_status;
    logic [SW-1:0]         res_slot;
    logic [ITEM_WIDTH-1:0] res_item;

    // sign-extend (or trim) the 32-bit input into the stored item width
    assign item_in     = ITEM_WIDTH'(value);
    assign handle_slot = SW'(handle_reg);
    assign prev_slot   = (action_reg == ACT_INS_AFTER) ? handle_slot : tail_reg;
    assign at_tail     = (cur_reg == tail_reg);

    assign sts.action    = action_reg;
    assign sts.nonempty  = nonempty_reg;
    assign sts.handle_ok = nonempty_reg && (int'(handle_reg) < POOL_DEPTH)
                           && in_use_reg[handle_slot];
    assign sts.scan_free = !in_use_reg[scan_reg];
    assign sts.scan_last = (scan_reg == LAST_IDX);
    assign sts.hit       = (rd_val_reg == item_reg);
    assign sts.at_tail   = at_tail;
    assign sts.cnt_last  = (cnt_reg == LAST_IDX);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_TAIL: rd_addr = tail_reg;
            RD_PREV: rd_addr = prev_slot;
            RD_LINK: rd_addr = rd_link_reg;
            default: rd_addr = tail_reg;
        endcase
    end

    // single write port on the link memory
    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = slot_reg;
        link_wdata = slot_reg;
        if (cmd.ins_node)
        begin
            link_we    = 1'b1;
            link_wdata = nonempty_reg ? rd_link_reg : slot_reg;
        end
        else if (cmd.link_prev)
        begin
            link_we    = 1'b1;
            link_waddr = prev_slot;
        end
        else if (cmd.del_head && !at_tail)
        begin
            link_we    = 1'b1;
            link_waddr = tail_reg;
            link_wdata = rd_link_reg;
        end
    end

    assign tail_moves = (action_reg == ACT_INS_BACK)
                        || ((action_reg == ACT_INS_AFTER) && (handle_slot == tail_reg));

    always_comb
    begin
        in_use_next   = in_use_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        if (cmd.ins_node)
        begin
            in_use_next[slot_reg] = 1'b1;
        end
        if (cmd.ins_first)
        begin
            tail_next     = slot_reg;
            nonempty_next = 1'b1;
        end
        if (cmd.link_prev && tail_moves)
        begin
            tail_next = slot_reg;
        end
        if (cmd.del_head)
        begin
            in_use_next[cur_reg] = 1'b0;
            if (at_tail)
            begin
                nonempty_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        res_status = ST_OK;
        res_slot   = '0;
        res_item   = '0;
        case (cmd.res_sel)
            RES_FULL:   res_status = ST_FULL;
            RES_BAD:    res_status = ST_BAD_HANDLE;
            RES_EMPTY:  res_status = ST_EMPTY;
            RES_MISS:   res_status = ST_NOT_FOUND;
            RES_INSERT:
            begin
                res_slot = slot_reg;
                res_item = item_reg;
            end
            RES_NODE:
            begin
                res_slot = cur_reg;
                res_item = rd_val_reg;
            end
            default:    res_status = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg   <= '0;
            tail_reg     <= '0;
            nonempty_reg <= 1'b0;
        end
        else
        begin
            in_use_reg   <= in_use_next;
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            action_reg <= action;
            item_reg   <= item_in;
            handle_reg <= handle;
        end
        if (cmd.scan_clr)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.slot_load)
        begin
            slot_reg <= scan_reg;
        end
        if (cmd.cur_load)
        begin
            cur_reg <= rd_link_reg;
        end
        if (cmd.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            status_reg      <= res_status;
            node_handle_reg <= 4'(res_slot);
            item_out_reg    <= 32'(res_item);
            last_result_reg <= cmd.out_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_node)
        begin
            val_mem[slot_reg] <= item_reg;
        end
        if (cmd.rd_en)
        begin
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_link_reg <= link_mem[rd_addr];
        end
    end

    assign status      = status_reg;
    assign node_handle = node_handle_reg;
    assign item_out    = item_out_reg;
    assign last_result = last_result_reg;

endmodule

@@ hw/rtl/circular_list_engine.sv @@
`timescale 1ns / 1ps
// Top level of the circular list engine: sequencer plus node pool datapath.
//
//  channel | beat fields                            | handshake
//  --------+----------------------------------------+--------------------
//  in      | action, value, handle                  | in_valid / in_ready
//  out     | status, node_handle, item_out,         | out_valid / out_ready
//          | last_result                            |
//
// One input beat at a time; in_ready is high only while the sequencer is idle.
// Each beat is decoded; empty list, bad handle and unknown actions end in DECODE. An insert
// scans one slot per cycle for a free one (1 to POOL_DEPTH), then INS_A and, if nonempty,
// INS_B; search and dump pass HEAD and one node per step, delete first HEAD and DELETE.
// Reset clears the in-use bits, tail and nonempty flag; node memories need no clearing.
// A stalled result holds the sequencer where it emits; a last beat waiting alone does not.
module circular_list_engine #(
    parameter int POOL_DEPTH = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         action,
    input  logic signed [31:0] value,
    input  logic [3:0]         handle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [3:0]         node_handle,
    output logic signed [31:0] item_out,
    output logic               last_result
);
    import cle_pkg::*;

    cmd_t cmd;   // sequencer -> datapath
    sts_t sts;   // datapath -> sequencer

    cle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cle_datapath #(
        .POOL_DEPTH (POOL_DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (action),
        .value       (value),
        .handle      (handle),
        .cmd         (cmd),
        .sts         (sts),
        .status      (status),
        .node_handle (node_handle),
        .item_out    (item_out),
        .last_result (last_result)
    );

`ifndef SYNTHESIS
    // only one beat in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a beat is still in work");

    // the result register is never overwritten while holding an untaken beat
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result register loaded over a pending beat");

    // only a dump produces more than one result beat
    a_multi_only_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_result) |-> (sts.action == ACT_DUMP))
        else $error("non-final result beat outside a dump");
`endif

endmodule

@@ dv/circular_list_engine_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the circular list engine: directed table, then random traffic.
module circular_list_engine_tb;
    import cle_pkg::*;

    localparam int POOL         = 16;
    localparam int HOLD_CYCLES  = 120;   // long result-side stall
    localparam int DRAIN_CYCLES = 60;    // settle time after the last result
    localparam int TIMEOUT_NS   = 600_000;

    // Actions 6 and 7 have no meaning; the block drops them without a result.
    localparam logic [2:0] ACT_RSVD_6 = 3'd6;
    localparam logic [2:0] ACT_RSVD_7 = 3'd7;

    // One result beat as the checker sees it.
    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         node;
        logic signed [31:0] item;
        logic               last;
    } res_t;

    // One row of the directed table. When typed is set, res is the hand-written
    // expectation; otherwise the list predictor supplies the results.
    typedef struct packed {
        logic [2:0]         act;
        logic signed [31:0] val;
        logic [3:0]         hnd;
        logic               typed;
        res_t               res;
    } row_t;

    // Random traffic is split into phases with different action mixes, so the
    // pool is driven all the way to full and back down to empty.
    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_BALANCED,
        MIX_SHRINK
    } mix_t;

    localparam res_t NO_RES       = '0;
    localparam int   PHASES       = 4;
    localparam mix_t PHASE_MIX[4] = '{MIX_GROW, MIX_BALANCED, MIX_SHRINK, MIX_BALANCED};
    localparam int   PHASE_LEN[4] = '{25, 20, 20, 8};

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [3:0]         handle;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic [3:0]         node_handle;
    logic signed [31:0] item_out;
    logic               last_result;

    circular_list_engine u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .value       (value),
        .handle      (handle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .node_handle (node_handle),
        .item_out    (item_out),
        .last_result (last_result)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the node pool. Only slots marked busy are ever read.
    // ------------------------------------------------------------------
    logic signed [31:0] pool_val  [POOL];
    logic [3:0]         pool_next [POOL];
    logic [POOL-1:0]    pool_busy = '0;
    logic [3:0]         end_slot  = '0;   // tail; head is its successor
    logic               has_nodes = 1'b0;

    res_t op_results[$];    // results of the beat just accepted
    res_t due_results[$];   // results still owed by the block, oldest first

    int   mismatches    = 0;
    int   results_seen  = 0;
    int   beats_by_act  [8];
    int   status_count  [8];
    int   burst_left    = 0;
    logic hold_off_req  = 1'b0;
    int   holds_done    = 0;

    function automatic int first_free_slot();
        for (int i = 0; i < POOL; i++)
            if (!pool_busy[i])
                return i;
        return -1;
    endfunction

    // Random busy slot, or -1 when the list is empty.
    function automatic int any_busy_slot();
        int picks[$];
        for (int i = 0; i < POOL; i++)
            if (pool_busy[i])
                picks.push_back(i);
        if (picks.size() == 0)
            return -1;
        return picks[$urandom_range(0, picks.size() - 1)];
    endfunction

    // New node goes into slot; on an empty list it links to itself and becomes
    // the tail, otherwise it is spliced in right after prev.
    task automatic link_node(input logic [3:0] slot, input logic signed [31:0] val,
                             input logic [3:0] prev);
        pool_val[slot]  = val;
        pool_busy[slot] = 1'b1;
        if (!has_nodes)
        begin
            pool_next[slot] = slot;
            end_slot        = slot;
            has_nodes       = 1'b1;
        end
        else
        begin
            pool_next[slot] = pool_next[prev];
            pool_next[prev] = slot;
        end
    endtask

    // Applies one action to the shadow list and fills op_results.
    task automatic run_list_op(input logic [2:0] act, input logic signed [31:0] val,
                               input logic [3:0] hnd);
        int         fs;
        logic [3:0] cur;
        logic [3:0] head;
        logic       hit;
        op_results.delete();
        fs  = first_free_slot();
        hit = 1'b0;
        cur = end_slot;
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK:
            begin
                if (fs < 0)
                    op_results.push_back('{ST_FULL, 4'd0, 32'sd0, 1'b1});
                else
                begin
                    // front: after tail, tail unchanged; back: new node becomes tail
                    link_node(4'(fs), val, end_slot);
                    if (act == ACT_INS_BACK)
                        end_slot = 4'(fs);
                    op_results.push_back('{ST_OK, 4'(fs), val, 1'b1});
                end
            end
            ACT_INS_AFTER:
            begin
                // handle check wins over the full check
                if (!has_nodes || !pool_busy[hnd])
                    op_results.push_back('{ST_BAD_HANDLE, 4'd0, 32'sd0, 1'b1});
                else if (fs < 0)
                    op_results.push_back('{ST_FULL, 4'd0, 32'sd0, 1'b1});
                else
                begin
                    link_node(4'(fs), val, hnd);
                    if (hnd == end_slot)
                        end_slot = 4'(fs);
                    op_results.push_back('{ST_OK, 4'(fs), val, 1'b1});
                end
            end
            ACT_SEARCH:
            begin
                if (has_nodes)
                begin
                    for (int n = 0; n < POOL; n++)
                    begin
                        cur = pool_next[cur];
                        if (pool_val[cur] == val)
                        begin
                            hit = 1'b1;
                            break;
                        end
                        if (cur == end_slot)
                            break;
                    end
                end
                if (hit)
                    op_results.push_back('{ST_OK, cur, pool_val[cur], 1'b1});
                else
                    op_results.push_back('{ST_NOT_FOUND, 4'd0, 32'sd0, 1'b1});
            end
            ACT_DEL_FIRST:
            begin
                if (!has_nodes)
                    op_results.push_back('{ST_EMPTY, 4'd0, 32'sd0, 1'b1});
                else
                begin
                    head = pool_next[end_slot];
                    if (head == end_slot)
                        has_nodes = 1'b0;       // last node gone
                    else
                        pool_next[end_slot] = pool_next[head];
                    pool_busy[head] = 1'b0;
                    op_results.push_back('{ST_OK, head, pool_val[head], 1'b1});
                end
            end
            ACT_DUMP:
            begin
                if (!has_nodes)
                    op_results.push_back('{ST_EMPTY, 4'd0, 32'sd0, 1'b1});
                else
                begin
                    // head to tail, capped at one pass over the pool
                    for (int n = 0; n < POOL; n++)
                    begin
                        cur = pool_next[cur];
                        op_results.push_back('{ST_OK, cur, pool_val[cur],
                                               (cur == end_slot) || (n == POOL - 1)});
                        if (cur == end_slot)
                            break;
                    end
                end
            end
            default:
            begin
                // reserved actions: no result
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Random field choosers
    // ------------------------------------------------------------------
    function automatic logic [2:0] pick_action(input mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 96)
            return ($urandom_range(0, 1) != 0) ? ACT_RSVD_6 : ACT_RSVD_7;
        case (mix)
            MIX_GROW:
            begin
                if (r < 70) return ($urandom_range(0, 1) != 0) ? ACT_INS_BACK : ACT_INS_FRONT;
                if (r < 80) return ACT_INS_AFTER;
                if (r < 88) return ACT_SEARCH;
                if (r < 92) return ACT_DUMP;
                return ACT_DEL_FIRST;
            end
            MIX_SHRINK:
            begin
                if (r < 60) return ACT_DEL_FIRST;
                if (r < 68) return ($urandom_range(0, 1) != 0) ? ACT_INS_BACK : ACT_INS_FRONT;
                if (r < 74) return ACT_INS_AFTER;
                if (r < 86) return ACT_SEARCH;
                return ACT_DUMP;
            end
            default:
            begin
                if (r < 22) return ($urandom_range(0, 1) != 0) ? ACT_INS_BACK : ACT_INS_FRONT;
                if (r < 40) return ACT_INS_AFTER;
                if (r < 58) return ACT_SEARCH;
                if (r < 76) return ACT_DEL_FIRST;
                return ACT_DUMP;
            end
        endcase
    endfunction

    // Small values make duplicates likely, so search has to return the first
    // match in list order; searches mostly aim at a value that is stored.
    function automatic logic signed [31:0] pick_value(input logic [2:0] act);
        int r;
        int s;
        r = $urandom_range(0, 99);
        s = any_busy_slot();
        if (act == ACT_SEARCH && s >= 0 && r < 60)
            return pool_val[s];
        if (r < 45)
            return int'($urandom_range(0, 15)) - 8;
        if (r < 60)
        begin
            case (r % 4)
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        if (s >= 0 && r < 70)
            return pool_val[s];
        return $urandom();
    endfunction

    function automatic logic [3:0] pick_handle();
        int s;
        s = any_busy_slot();
        if (s >= 0 && $urandom_range(0, 99) < 70)
            return 4'(s);
        return 4'($urandom_range(0, POOL - 1));
    endfunction

    // ------------------------------------------------------------------
    // Input side. Payload changes on the falling edge; a beat counts when
    // in_valid and in_ready are both high at a rising edge. Valid stays up
    // between back-to-back beats and only drops in a gap.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [2:0] act, input logic signed [31:0] val,
                             input logic [3:0] hnd, input logic typed, input res_t typed_res);
        @(negedge clk);
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        handle   <= hnd;
        do
            @(posedge clk);
        while (!in_ready);
        run_list_op(act, val, hnd);
        beats_by_act[act]++;
        if (typed)
            due_results.push_back(typed_res);
        else
            foreach (op_results[i])
                due_results.push_back(op_results[i]);
    endtask

    // Bursts of random length; now and then a long burst with no idling at all.
    task automatic burst_gap();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                      : $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side. out_ready follows a randomly chosen stall mode that changes
    // over the run; on request it holds off for HOLD_CYCLES so the block backs
    // up into its input.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int mode;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(8, 40))
            begin
                @(negedge clk);
                if (hold_off_req)
                begin
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_off_req = 1'b0;
                    holds_done++;
                end
                else
                begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= ($urandom_range(0, 3) != 0);
                        2:       out_ready <= ($urandom_range(0, 1) != 0);
                        default: out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // Every result beat is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            status_count[status]++;
            if (due_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with nothing expected: status %0d node %0d item %0d",
                         $time, status, node_handle, item_out);
            end
            else
            begin
                want = due_results.pop_front();
                if (status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d got %0d", $time, want.status, status);
                end
                if (node_handle !== want.node)
                begin
                    mismatches++;
                    $display("%0t: node_handle expected %0d got %0d",
                             $time, want.node, node_handle);
                end
                if (item_out !== want.item)
                begin
                    mismatches++;
                    $display("%0t: item_out expected %0d got %0d", $time, want.item, item_out);
                end
                if (last_result !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last_result expected %0d got %0d",
                             $time, want.last, last_result);
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #TIMEOUT_NS;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        row_t       plan[$];
        logic [2:0] act;
        int         done;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        action   = '0;
        value    = '0;
        handle   = '0;
        foreach (beats_by_act[i]) beats_by_act[i] = 0;
        foreach (status_count[i]) status_count[i] = 0;

        // Directed table. Walks: empty-list errors, reserved actions, extreme
        // values, bad handles, search hit/miss, insert after the tail, dump,
        // delete down through the one-node case, then reuse of slot 0.
        plan.push_back('{ACT_DUMP,      32'sd0, 4'd0, 1'b1, '{ST_EMPTY, 4'd0, 32'sd0, 1'b1}});
        plan.push_back('{ACT_DEL_FIRST, 32'sd0, 4'd0, 1'b1, '{ST_EMPTY, 4'd0, 32'sd0, 1'b1}});
        plan.push_back('{ACT_SEARCH,    32'sd5, 4'd0, 1'b1,
                         '{ST_NOT_FOUND, 4'd0, 32'sd0, 1'b1}});
        plan.push_back('{ACT_INS_AFTER, 32'sd9, 4'd0, 1'b1,
                         '{ST_BAD_HANDLE, 4'd0, 32'sd0, 1'b1}});
        plan.push_back('{ACT_RSVD_6,    32'sd1, 4'd3, 1'b0, NO_RES});
        plan.push_back('{ACT_RSVD_7,    32'sd2, 4'd15, 1'b0, NO_RES});
        plan.push_back('{ACT_INS_FRONT, 32'sh8000_0000, 4'd0, 1'b1,
                         '{ST_OK, 4'd0, 32'sh8000_0000, 1'b1}});
        plan.push_back('{ACT_INS_BACK,  32'sh7fff_ffff, 4'd0, 1'b1,
                         '{ST_OK, 4'd1, 32'sh7fff_ffff, 1'b1}});
        plan.push_back('{ACT_INS_AFTER, 32'sd1, 4'd15, 1'b1,
                         '{ST_BAD_HANDLE, 4'd0, 32'sd0, 1'b1}});
        plan.push_back('{ACT_INS_AFTER, 32'sd0, 4'd0, 1'b0, NO_RES});
        plan.push_back('{ACT_INS_FRONT, -32'sd1, 4'd0, 1'b0, NO_RES});
        plan.push_back('{ACT_SEARCH,    32'sh7fff_ffff, 4'd0, 1'b0, NO_RES});
        plan.push_back('{ACT_SEARCH,    32'sh8000_0000, 4'd0, 1'b0, NO_RES});
        plan.push_back('{ACT_SEARCH,    32'sd12345, 4'd0, 1'b1,
                         '{ST_NOT_FOUND, 4'd0, 32'sd0, 1'b1}});
        plan.push_back('{ACT_DUMP,      32'sd0, 4'd0, 1'b0, NO_RES});
        plan.push_back('{ACT_INS_AFTER, 32'sd7, 4'd1, 1'b0, NO_RES});   // after tail
        plan.push_back('{ACT_DUMP,      32'sd0, 4'd0, 1'b0, NO_RES});
        repeat (5)
            plan.push_back('{ACT_DEL_FIRST, 32'sd0, 4'd0, 1'b0, NO_RES});
        plan.push_back('{ACT_DEL_FIRST, 32'sd0, 4'd0, 1'b1, '{ST_EMPTY, 4'd0, 32'sd0, 1'b1}});
        plan.push_back('{ACT_INS_BACK,  32'sh5555_5555, 4'd0, 1'b1,
                         '{ST_OK, 4'd0, 32'sh5555_5555, 1'b1}});
        plan.push_back('{ACT_SEARCH,    32'sh5555_5555, 4'd0, 1'b0, NO_RES});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            send_item(plan[i].act, plan[i].val, plan[i].hnd, plan[i].typed, plan[i].res);
            burst_gap();
        end

        // Random phases. Reserved actions do not count toward a phase length.
        for (int p = 0; p < PHASES; p++)
        begin
            if (PHASE_MIX[p] == MIX_SHRINK)
            begin
                // full drain: stop offering until every owed result is out
                @(negedge clk);
                in_valid <= 1'b0;
                wait (due_results.size() == 0);
            end
            done = 0;
            while (done < PHASE_LEN[p])
            begin
                act = pick_action(PHASE_MIX[p]);
                if (p == 1 && done == 5)
                    hold_off_req = 1'b1;    // long output stall while input keeps coming
                send_item(act, pick_value(act), pick_handle(), 1'b0, NO_RES);
                if (act != ACT_RSVD_6 && act != ACT_RSVD_7)
                    done++;
                burst_gap();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (due_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Beats: front %0d back %0d search %0d after %0d delete %0d dump %0d rsvd %0d",
                 beats_by_act[ACT_INS_FRONT], beats_by_act[ACT_INS_BACK],
                 beats_by_act[ACT_SEARCH], beats_by_act[ACT_INS_AFTER],
                 beats_by_act[ACT_DEL_FIRST], beats_by_act[ACT_DUMP],
                 beats_by_act[ACT_RSVD_6] + beats_by_act[ACT_RSVD_7]);
        $display("Results %0d: ok %0d full %0d empty %0d miss %0d bad %0d; long holds %0d",
                 results_seen, status_count[ST_OK], status_count[ST_FULL],
                 status_count[ST_EMPTY], status_count[ST_NOT_FOUND],
                 status_count[ST_BAD_HANDLE], holds_done);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/cle_pkg.sv
hw/rtl/cle_ctrl.sv
hw/rtl/cle_datapath.sv
hw/rtl/circular_list_engine.sv
dv/circular_list_engine_tb.sv
